FILE: rtl/dque_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dque_pkg;

    // Widths fixed by the item and result fields.
    localparam int WORD_W = 32;
    localparam int MODE_W = 2;
    localparam int OCC_W  = 7;

    // Operation requested by one input beat.
    typedef enum logic [MODE_W-1:0] {
        MODE_PUSH_BACK  = 2'd0,
        MODE_PUSH_FRONT = 2'd1,
        MODE_POP_FRONT  = 2'd2,
        MODE_POP_BACK   = 2'd3
    } t_mode;

    // Controller states.
    typedef enum logic {
        ST_IDLE,
        ST_RESPOND
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic push;
        logic pop;
        logic at_front;
        logic err;
    } t_dq_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic empty;
        logic full;
    } t_dq_status;

endpackage

`default_nettype wire

FILE: rtl/dque_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module dque_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/dque_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module dque_ctrl
    import dque_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic [MODE_W-1:0]  i_mode,
    input  wire t_dq_status         i_status,
    output t_dq_cmd                 o_cmd,
    output logic                    o_busy,
    output logic                    o_valid
);

    t_state r_state;
    t_state n_state;
    logic   is_push;
    logic   at_front;
    logic   refused;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Decode the requested operation.
    always_comb begin
        is_push  = 1'b0;
        at_front = 1'b0;
        case (t_mode'(i_mode))
            MODE_PUSH_BACK: begin
                is_push  = 1'b1;
                at_front = 1'b0;
            end
            MODE_PUSH_FRONT: begin
                is_push  = 1'b1;
                at_front = 1'b1;
            end
            MODE_POP_FRONT: begin
                is_push  = 1'b0;
                at_front = 1'b1;
            end
            MODE_POP_BACK: begin
                is_push  = 1'b0;
                at_front = 1'b0;
            end
            default: begin
                is_push  = 1'b0;
                at_front = 1'b0;
            end
        endcase
    end

    // A push into a full queue or a pop from an empty one is refused.
    assign refused = is_push ? i_status.full : i_status.empty;

    // Next state, commands and handshake outputs.
    always_comb begin
        n_state         = r_state;
        o_busy          = 1'b0;
        o_valid         = 1'b0;
        o_cmd.accept    = i_start && !o_busy;
        o_cmd.push      = o_cmd.accept && is_push && !refused;
        o_cmd.pop       = o_cmd.accept && !is_push && !refused;
        o_cmd.at_front  = at_front;
        o_cmd.err       = o_cmd.accept && refused;
        case (r_state)
            ST_IDLE: begin
                n_state = o_cmd.accept ? ST_RESPOND : ST_IDLE;
            end
            ST_RESPOND: begin
                o_valid = 1'b1;
                n_state = o_cmd.accept ? ST_RESPOND : ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // A result beat always follows an accepted item in the next cycle.
    a_valid_follows_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.accept |=> o_valid)
        else $error("result strobe missing after an accepted item");

    // At most one of push, pop and refusal per beat.
    a_cmd_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.push, o_cmd.pop, o_cmd.err}))
        else $error("conflicting datapath commands");

    // No store command without an accepted item.
    a_cmd_needs_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_cmd.accept |-> !(o_cmd.push || o_cmd.pop || o_cmd.err))
        else $error("command issued with no item accepted");

endmodule

`default_nettype wire

FILE: rtl/dque_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module dque_dp
    import dque_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire t_dq_cmd                  i_cmd,
    input  wire logic signed [WORD_W-1:0] i_push_value,
    output t_dq_status                    o_status,
    output logic signed      [WORD_W-1:0] o_pop_value,
    output logic                          o_op_error,
    output logic                          o_is_empty,
    output logic                          o_is_full,
    output logic             [OCC_W-1:0]  o_occupancy
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [AW-1:0]     r_front;
    logic [AW-1:0]     n_front;
    logic [AW-1:0]     r_back;
    logic [AW-1:0]     n_back;
    logic [CW-1:0]     r_count;
    logic [CW-1:0]     n_count;
    logic              r_err;
    logic              r_pop_ok;
    logic [AW-1:0]     front_up;
    logic [AW-1:0]     front_dn;
    logic [AW-1:0]     back_up;
    logic [AW-1:0]     back_dn;
    logic [AW-1:0]     addr;
    logic [WORD_W-1:0] rd_data;

    // Neighbouring slots of each end, wrapping round the store.
    assign front_up = (r_front == AW'(DEPTH - 1)) ? '0 : r_front + 1'b1;
    assign front_dn = (r_front == '0) ? AW'(DEPTH - 1) : r_front - 1'b1;
    assign back_up  = (r_back == AW'(DEPTH - 1)) ? '0 : r_back + 1'b1;
    assign back_dn  = (r_back == '0) ? AW'(DEPTH - 1) : r_back - 1'b1;

    // Slot touched by the operation: front pushes and back pops step first.
    always_comb begin
        if (i_cmd.at_front) begin
            addr = i_cmd.push ? front_dn : r_front;
        end else begin
            addr = i_cmd.push ? r_back : back_dn;
        end
    end

    // Pointer and count updates.
    always_comb begin
        n_front = r_front;
        n_back  = r_back;
        n_count = r_count;
        if (i_cmd.push) begin
            n_count = r_count + 1'b1;
            if (i_cmd.at_front) begin
                n_front = front_dn;
            end else begin
                n_back = back_up;
            end
        end else if (i_cmd.pop) begin
            n_count = r_count - 1'b1;
            if (i_cmd.at_front) begin
                n_front = front_up;
            end else begin
                n_back = back_dn;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front  <= '0;
            r_back   <= '0;
            r_count  <= '0;
            r_err    <= 1'b0;
            r_pop_ok <= 1'b0;
        end else begin
            r_front <= n_front;
            r_back  <= n_back;
            r_count <= n_count;
            if (i_cmd.accept) begin
                r_err    <= i_cmd.err;
                r_pop_ok <= i_cmd.pop;
            end
        end
    end

    // Word store.
    dque_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.push),
        .i_wr_addr (addr),
        .i_wr_data (i_push_value),
        .i_rd_en   (i_cmd.pop),
        .i_rd_addr (addr),
        .o_rd_data (rd_data)
    );

    // Status and result fields; the count register already holds the new count.
    assign o_status.empty = (r_count == '0);
    assign o_status.full  = (r_count == CW'(DEPTH));
    assign o_pop_value    = r_pop_ok ? rd_data : '0;
    assign o_op_error     = r_err;
    assign o_is_empty     = o_status.empty;
    assign o_is_full      = o_status.full;
    assign o_occupancy    = OCC_W'(r_count);

    // The count never passes the capacity.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("word count beyond capacity");

    // A refused operation leaves the queue as it was.
    a_refused_no_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.err |=> $stable(r_count) && $stable(r_front) && $stable(r_back))
        else $error("refused operation changed the queue");

    // A pop result never reports an error.
    a_pop_no_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pop_ok |-> !r_err)
        else $error("popped word flagged as an error");

endmodule

`default_nettype wire

FILE: rtl/double_ended_queue.sv
`timescale 1ns / 1ps
`default_nettype none

// Latency: the result beat is strobed on o_valid in the cycle after start is taken.
// Throughput: one item per cycle; busy stays low, the receiver cannot stall.
// o_valid and the popped word are registered, the word by the store RAM read port.
// Reset (synchronous, active low) empties the queue and clears both end pointers.
// Store contents are not cleared; only slots written by a push are ever read back.

module double_ended_queue
    import dque_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     start,
    output logic                          busy,
    input  wire logic        [MODE_W-1:0] i_mode,
    input  wire logic signed [WORD_W-1:0] i_push_value,
    output logic                          o_valid,
    output logic signed      [WORD_W-1:0] o_pop_value,
    output logic                          o_op_error,
    output logic                          o_is_empty,
    output logic                          o_is_full,
    output logic             [OCC_W-1:0]  o_occupancy
);

    t_dq_cmd    cmd;
    t_dq_status status;

    // Operation sequencing.
    dque_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_mode   (i_mode),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy),
        .o_valid  (o_valid)
    );

    // Pointers, count and word store.
    dque_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_push_value (i_push_value),
        .o_status     (status),
        .o_pop_value  (o_pop_value),
        .o_op_error   (o_op_error),
        .o_is_empty   (o_is_empty),
        .o_is_full    (o_is_full),
        .o_occupancy  (o_occupancy)
    );

endmodule

`default_nettype wire
